>>> src/frame_capture_slot_scheduler_macros.svh
// Assertion macros of the frame capture slot scheduler, used by the sequencer
`ifndef FRAME_CAPTURE_SLOT_SCHEDULER_MACROS_SVH
`define FRAME_CAPTURE_SLOT_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define FCSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define FCSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fcss_pkg.sv
// Types, constants and codes of the frame capture slot scheduler
package fcss_pkg;

  localparam int SLOT_COUNT   = 8;
  localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MAX_CAPTURES = 8;
  localparam int CAP_W        = $clog2(MAX_CAPTURES + 1);

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_ADD   = 3'd1,
    REQ_LIST  = 3'd2,
    REQ_ENDALL = 3'd3,
    REQ_CLEAN = 3'd4
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LIST_OK    = 3'd1,
    ST_CAPTURE    = 3'd2,
    ST_NO_FREE    = 3'd3,
    ST_NO_MATCH   = 3'd4,
    ST_BAD_SLOT   = 3'd5,
    ST_FRAME_DONE = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now;
    logic [23:0] total;
    logic [15:0] skip;
    logic [31:0] start;
    logic        with_list;
    logic [15:0] key;
    logic [2:0]  sel;
  } req_t;

  // rem tracks phase modulo (skip + 1) so no divider is needed
  typedef struct packed {
    logic [23:0] frames;
    logic [15:0] skip;
    logic [15:0] phase;
    logic [15:0] rem;
    logic [31:0] start;
    logic        stack;
    logic        ready;
    logic [15:0] owner;
  } slot_data_t;

  typedef struct packed {
    logic       active;
    slot_data_t data;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    slot_entry_t       entry;
  } slot_wr_t;

  typedef struct packed {
    logic        wr;
    logic        hit;
    logic        fin;
    slot_entry_t entry;
  } eval_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic        stack;
    logic        fin;
    logic [15:0] key;
    logic        last;
  } result_t;

endpackage

>>> src/frame_capture_slot_scheduler.sv
// Frame capture slot scheduler: SLOT_COUNT capture slots served by one shared
// slot unit that a sequencer steps over the table one slot per cycle. A
// request is taken, then the block is busy: a frame tick takes SLOT_COUNT
// slot steps and then issues a frame-done result; end-all walks the same
// way and ends with an OK result; add and pixel-list-complete take up to
// SLOT_COUNT steps and stop early at the first free or matching slot, with a
// final not-found result when nothing is found; clean-slot takes one step;
// an unknown request code is taken and dropped. Any cycle in which a result
// cannot be transferred because the output register is full holds the walk.
// The last result of a request sits in the output register while the next
// request is accepted.
module frame_capture_slot_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] now_time,
  input  logic [23:0] frame_total,
  input  logic [15:0] skip_frames,
  input  logic [31:0] start_time,
  input  logic        with_pixel_list,
  input  logic [15:0] requester_key,
  input  logic [2:0]  slot_select,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic [2:0]  slot_index,
  output logic        is_stack,
  output logic        finished,
  output logic [15:0] notify_key,
  output logic        last_result
);
  import fcss_pkg::*;

  req_t              req_in;
  logic              busy;
  logic              out_free;
  logic              emit;
  result_t           res, res_q;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;
  slot_entry_t       entry;
  slot_wr_t          wr;

  assign req_in.kind      = req_type;
  assign req_in.now       = now_time;
  assign req_in.total     = frame_total;
  assign req_in.skip      = skip_frames;
  assign req_in.start     = start_time;
  assign req_in.with_list = with_pixel_list;
  assign req_in.key       = requester_key;
  assign req_in.sel       = slot_select;

  assign req_stall = busy;
  assign out_free  = !res_valid || !res_stall;

  fcss_slot_table u_table (
    .clk         (clk),
    .rst         (rst),
    .rd_idx      (idx),
    .rd_idx_next (idx_next),
    .wr          (wr),
    .rd_entry    (entry)
  );

  fcss_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_in    (req_in),
    .busy      (busy),
    .out_free  (out_free),
    .emit      (emit),
    .res       (res),
    .idx       (idx),
    .idx_next  (idx_next),
    .entry     (entry),
    .wr        (wr)
  );

  // output register: load on a new result, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign status      = res_q.status;
  assign slot_index  = res_q.slot;
  assign is_stack    = res_q.stack;
  assign finished    = res_q.fin;
  assign notify_key  = res_q.key;
  assign last_result = res_q.last;

endmodule

>>> src/fcss_slot_table.sv
// Slot table: active bits with reset, slot payload without reset
module fcss_slot_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [fcss_pkg::SLOT_W-1:0] rd_idx,
  input  logic [fcss_pkg::SLOT_W-1:0] rd_idx_next,
  input  fcss_pkg::slot_wr_t        wr,
  output fcss_pkg::slot_entry_t     rd_entry
);
  import fcss_pkg::*;

  logic [SLOT_COUNT-1:0] active;
  slot_data_t            data_mem [SLOT_COUNT];
  slot_data_t            data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (wr.en) begin
      active[wr.idx] <= wr.entry.active;
    end
  end

  // register the payload read at the index the sequencer moves to, so it lines up with idx
  always_ff @(posedge clk) begin
    if (wr.en) begin
      data_mem[wr.idx] <= wr.entry.data;
    end
    data_q <= data_mem[rd_idx_next];
  end

  assign rd_entry.active = active[rd_idx];
  assign rd_entry.data   = data_q;

endmodule

>>> src/fcss_slot_eval.sv
// Shared slot unit: evaluates one slot entry against the current request
module fcss_slot_eval (
  input  fcss_pkg::req_t        req,
  input  fcss_pkg::slot_entry_t entry,
  output fcss_pkg::eval_t       ev
);
  import fcss_pkg::*;

  logic eligible;
  logic capture;

  assign eligible = entry.active && (req.now >= entry.data.start) &&
                    !(entry.data.stack && !entry.data.ready);

  always_comb begin
    ev       = '0;
    ev.entry = entry;
    capture  = 1'b0;
    case (req.kind)
      REQ_TICK: begin
        if (eligible) begin
          ev.wr   = 1'b1;
          capture = 1'b1;
          if (entry.data.skip != 16'd0) begin
            ev.entry.data.phase = entry.data.phase + 16'd1;
            // restart the remainder when it reaches skip or the phase counter wraps to zero
            if (entry.data.phase == 16'hFFFF || entry.data.rem == entry.data.skip) begin
              ev.entry.data.rem = 16'd0;
            end else begin
              ev.entry.data.rem = entry.data.rem + 16'd1;
            end
            capture = (entry.data.rem == 16'd0);
          end
          if (capture && entry.data.frames != 24'd0) begin
            ev.entry.data.frames = entry.data.frames - 24'd1;
            if (entry.data.frames == 24'd1) begin
              ev.fin          = 1'b1;
              ev.entry.active = 1'b0;
            end
          end
        end
        ev.hit = capture;
      end
      REQ_ADD: begin
        ev.hit                = !entry.active;
        ev.wr                 = !entry.active;
        ev.entry.active       = 1'b1;
        ev.entry.data.frames  = req.total;
        ev.entry.data.skip    = req.skip;
        ev.entry.data.phase   = 16'd0;
        ev.entry.data.rem     = 16'd0;
        ev.entry.data.start   = req.start;
        ev.entry.data.stack   = req.with_list;
        ev.entry.data.ready   = 1'b0;
        ev.entry.data.owner   = req.key;
      end
      REQ_LIST: begin
        ev.hit              = entry.active && (entry.data.owner == req.key);
        ev.wr               = ev.hit;
        ev.entry.data.ready = 1'b1;
      end
      REQ_ENDALL: begin
        ev.wr                = 1'b1;
        ev.entry.data.frames = 24'd1;
      end
      REQ_CLEAN: begin
        ev.hit   = (32'(req.sel) < 32'(SLOT_COUNT));
        ev.wr    = ev.hit;
        ev.entry = '0;
      end
      default: begin
        ev = '0;
      end
    endcase
  end

endmodule

>>> src/fcss_seq.sv
// Sequencer: latches a request, walks the slot table and issues results
`include "frame_capture_slot_scheduler_macros.svh"

module fcss_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  fcss_pkg::req_t              req_in,
  output logic                        busy,
  input  logic                        out_free,
  output logic                        emit,
  output fcss_pkg::result_t           res,
  output logic [fcss_pkg::SLOT_W-1:0] idx,
  output logic [fcss_pkg::SLOT_W-1:0] idx_next,
  input  fcss_pkg::slot_entry_t       entry,
  output fcss_pkg::slot_wr_t          wr
);
  import fcss_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  seq_state_t        state, state_next;
  req_t              req, req_next;
  logic [CAP_W-1:0]  cap_cnt, cap_cnt_next;
  logic [2:0]        fin_status, fin_status_next;
  eval_t             ev;
  logic              at_last;

  fcss_slot_eval u_eval (
    .req   (req),
    .entry (entry),
    .ev    (ev)
  );

  assign at_last = (idx == SLOT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      cap_cnt <= '0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      cap_cnt <= cap_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    fin_status <= fin_status_next;
  end

  always_comb begin
    state_next      = state;
    req_next        = req;
    idx_next        = idx;
    cap_cnt_next    = cap_cnt;
    fin_status_next = fin_status;
    emit            = 1'b0;
    res             = '0;
    wr.en           = 1'b0;
    wr.idx          = idx;
    wr.entry        = ev.entry;
    busy            = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_next     = req_in;
          cap_cnt_next = '0;
          idx_next     = (req_in.kind == REQ_CLEAN) ? SLOT_W'(req_in.sel) : '0;
          // unknown request codes are taken and dropped
          if (req_in.kind <= REQ_CLEAN) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          wr.en = ev.wr;
          case (req.kind)
            REQ_TICK: begin
              if (ev.hit && cap_cnt < CAP_W'(MAX_CAPTURES)) begin
                emit         = 1'b1;
                res.status   = ST_CAPTURE;
                res.slot     = 3'(idx);
                res.stack    = entry.data.stack;
                res.fin      = ev.fin;
                res.key      = ev.fin ? entry.data.owner : 16'd0;
                cap_cnt_next = cap_cnt + CAP_W'(1);
              end
              if (at_last) begin
                fin_status_next = ST_FRAME_DONE;
                state_next      = S_FINAL;
              end else begin
                idx_next = idx + SLOT_W'(1);
              end
            end
            REQ_ADD, REQ_LIST: begin
              if (ev.hit) begin
                emit       = 1'b1;
                res.status = (req.kind == REQ_ADD) ? ST_OK : ST_LIST_OK;
                res.slot   = 3'(idx);
                res.stack  = (req.kind == REQ_ADD) ? req.with_list : entry.data.stack;
                res.key    = req.key;
                res.last   = 1'b1;
                state_next = S_IDLE;
              end else if (at_last) begin
                fin_status_next = (req.kind == REQ_ADD) ? ST_NO_FREE : ST_NO_MATCH;
                state_next      = S_FINAL;
              end else begin
                idx_next = idx + SLOT_W'(1);
              end
            end
            REQ_ENDALL: begin
              if (at_last) begin
                fin_status_next = ST_OK;
                state_next      = S_FINAL;
              end else begin
                idx_next = idx + SLOT_W'(1);
              end
            end
            REQ_CLEAN: begin
              emit       = 1'b1;
              res.status = ev.hit ? ST_OK : ST_BAD_SLOT;
              res.slot   = req.sel;
              res.key    = req.key;
              res.last   = 1'b1;
              state_next = S_IDLE;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FINAL: begin
        if (out_free) begin
          emit       = 1'b1;
          res.status = fin_status;
          res.key    = (req.kind == REQ_TICK) ? 16'd0 : req.key;
          res.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `FCSS_ASSERT_IMP(a_emit_into_free, emit, out_free, "result issued into a full output register")
  `FCSS_ASSERT_NEXT(a_last_ends_item, emit && res.last, state == S_IDLE, "busy after last result")
  `FCSS_ASSERT_IMP(a_cap_bound, 1'b1, cap_cnt <= CAP_W'(MAX_CAPTURES), "capture count past limit")
  `FCSS_ASSERT_IMP(a_scan_write_free, wr.en, out_free && state == S_SCAN, "write outside a scan")

endmodule
